### hdl/fsmatch_pkg.sv
package fsmatch_pkg;

  // One pattern or text character.
  typedef logic [7:0] byte_t;

  // Codes carried on the func field.
  localparam logic FUNC_PATTERN = 1'b0;
  localparam logic FUNC_TEXT    = 1'b1;

  // Default sizes for the top level.
  localparam int MAX_PATTERN_DEF = 32;
  localparam int INDEX_WIDTH_DEF = 16;

endpackage

### hdl/first_substring_match.sv
// Channel  | Handshake            | Payload
// ---------+----------------------+----------------------------------------------
// in       | in_valid / in_ready  | func, data_byte, has_byte, last_of_string
// out      | out_valid / out_ready| found, match_index
//
// A new input transaction is accepted in every cycle while in_ready is high.
// The window compare runs in a row of MAX_PATTERN cells, one per window byte, in the
// accepting cycle; a result goes to the output register, or to the skid stage while one waits.
// A two-entry output buffer (output register plus skid stage) lets input flow on while a
// result waits; in_ready drops only when both entries are full.
// Synchronous reset empties the pattern and the search state; pattern and window bytes
// themselves are not cleared.
module first_substring_match #(
  parameter int MAX_PATTERN = fsmatch_pkg::MAX_PATTERN_DEF,
  parameter int INDEX_WIDTH = fsmatch_pkg::INDEX_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  func,
  input  fsmatch_pkg::byte_t    data_byte,
  input  logic                  has_byte,
  input  logic                  last_of_string,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  found,
  output logic signed [INDEX_WIDTH:0] match_index
);
  import fsmatch_pkg::*;

  localparam int CountWidth = INDEX_WIDTH + 1;
  localparam int LenWidth   = $clog2(MAX_PATTERN + 1);
  localparam int CmpWidth   = (CountWidth > LenWidth) ? CountWidth : LenWidth;

  logic [LenWidth-1:0]    pattern_length, pattern_length_next;
  logic                   pattern_closed, pattern_closed_next;
  logic [CountWidth-1:0]  text_count, text_count_next;
  logic                   match_seen, match_seen_next;
  logic [INDEX_WIDTH-1:0] first_index, first_index_next;

  logic                   in_fire;
  logic                   is_pattern;
  logic [LenWidth-1:0]    len_base;
  logic                   pat_append;
  logic                   text_shift;
  logic                   counted;
  logic [CountWidth-1:0]  count_inc;
  logic [CmpWidth-1:0]    count_ext;
  logic [CmpWidth-1:0]    len_ext;
  logic [CmpWidth-1:0]    start;
  logic                   all_hit;
  logic                   record;
  logic                   push;
  logic                   res_found;
  logic [INDEX_WIDTH:0]   res_index;
  logic                   obuf_full;
  logic [INDEX_WIDTH:0]   out_index;

  byte_t                  win_chain [MAX_PATTERN];
  byte_t                  pat_chain [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] hit;

  assign in_ready   = !obuf_full;
  assign in_fire    = in_valid && in_ready;
  assign is_pattern = (func == FUNC_PATTERN);

  // Pattern growth: a closed pattern restarts from empty, extra bytes are dropped.
  assign len_base   = pattern_closed ? '0 : pattern_length;
  assign pat_append = in_fire && is_pattern && has_byte &&
                      (len_base < LenWidth'(MAX_PATTERN));
  assign text_shift = in_fire && !is_pattern && has_byte;

  // Row of compare cells; new bytes enter at cell zero.
  assign win_chain[0] = data_byte;
  assign pat_chain[0] = data_byte;

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    if (k < MAX_PATTERN - 1) begin : g_mid
      fsmatch_cell #(
        .IDX       (k),
        .LEN_WIDTH (LenWidth)
      ) u_cell (
        .clk            (clk),
        .win_shift      (text_shift),
        .pat_shift      (pat_append),
        .win_in         (win_chain[k]),
        .pat_in         (pat_chain[k]),
        .pattern_length (pattern_length),
        .win_out        (win_chain[k+1]),
        .pat_out        (pat_chain[k+1]),
        .hit            (hit[k])
      );
    end else begin : g_end
      fsmatch_cell #(
        .IDX       (k),
        .LEN_WIDTH (LenWidth)
      ) u_cell (
        .clk            (clk),
        .win_shift      (text_shift),
        .pat_shift      (pat_append),
        .win_in         (win_chain[k]),
        .pat_in         (pat_chain[k]),
        .pattern_length (pattern_length),
        .win_out        (),
        .pat_out        (),
        .hit            (hit[k])
      );
    end
  end

  assign all_hit = &hit;

  // Text position and candidate start index of a match ending at this byte.
  assign counted   = (text_count != '1);
  assign count_inc = text_count + 1'b1;
  assign count_ext = CmpWidth'(count_inc);
  assign len_ext   = CmpWidth'(pattern_length);
  assign start     = count_ext - len_ext;

  assign record = text_shift && counted && !match_seen && (pattern_length != '0) &&
                  (count_ext >= len_ext) && (start[CmpWidth-1:INDEX_WIDTH] == '0) &&
                  all_hit;

  // Result of the transaction that ends the text.
  assign push      = in_fire && !is_pattern && last_of_string;
  assign res_found = (pattern_length == '0) || match_seen || record;

  always_comb begin
    if (pattern_length == '0) begin
      res_index = '0;
    end else if (match_seen) begin
      res_index = {1'b0, first_index};
    end else if (record) begin
      res_index = {1'b0, start[INDEX_WIDTH-1:0]};
    end else begin
      res_index = '1;
    end
  end

  // Next state of the pattern and search registers.
  always_comb begin
    pattern_length_next = pattern_length;
    pattern_closed_next = pattern_closed;
    text_count_next     = text_count;
    match_seen_next     = match_seen;
    first_index_next    = first_index;
    if (in_fire && is_pattern) begin
      pattern_length_next = pat_append ? (len_base + 1'b1) : len_base;
      pattern_closed_next = last_of_string;
    end else if (in_fire) begin
      if (text_shift && counted) begin
        text_count_next = count_inc;
      end
      if (record) begin
        match_seen_next  = 1'b1;
        first_index_next = start[INDEX_WIDTH-1:0];
      end
      if (last_of_string) begin
        text_count_next  = '0;
        match_seen_next  = 1'b0;
        first_index_next = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= '0;
      pattern_closed <= 1'b1;
      text_count     <= '0;
      match_seen     <= 1'b0;
      first_index    <= '0;
    end else begin
      pattern_length <= pattern_length_next;
      pattern_closed <= pattern_closed_next;
      text_count     <= text_count_next;
      match_seen     <= match_seen_next;
      first_index    <= first_index_next;
    end
  end

  // Output register with skid stage.
  fsmatch_obuf #(
    .INDEX_WIDTH (INDEX_WIDTH)
  ) u_obuf (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .push_found  (res_found),
    .push_index  (res_index),
    .full        (obuf_full),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .found       (found),
    .match_index (out_index)
  );

  assign match_index = $signed(out_index);

  // The end of a text always leaves a result behind and a fresh search state.
  a_end_gives_result: assert property (@(posedge clk) disable iff (rst)
    push |=> out_valid)
    else $error("text end did not produce a result");

  a_end_clears_search: assert property (@(posedge clk) disable iff (rst)
    push |=> (text_count == '0 && !match_seen && first_index == '0))
    else $error("search state not cleared after text end");

  // A recorded match never starts past the current text position.
  a_match_in_range: assert property (@(posedge clk) disable iff (rst)
    match_seen |-> (CountWidth'(first_index) < text_count))
    else $error("recorded match start lies beyond the text position");

endmodule

### hdl/fsmatch_cell.sv
module fsmatch_cell #(
  parameter int IDX       = 0,
  parameter int LEN_WIDTH = 6
) (
  input  logic                  clk,
  input  logic                  win_shift,
  input  logic                  pat_shift,
  input  fsmatch_pkg::byte_t    win_in,
  input  fsmatch_pkg::byte_t    pat_in,
  input  logic [LEN_WIDTH-1:0]  pattern_length,
  output fsmatch_pkg::byte_t    win_out,
  output fsmatch_pkg::byte_t    pat_out,
  output logic                  hit
);
  import fsmatch_pkg::*;

  byte_t win;
  byte_t pat;

  // The window byte and the pattern byte each move one cell up when their string grows.
  always_ff @(posedge clk) begin
    if (win_shift) begin
      win <= win_in;
    end
    if (pat_shift) begin
      pat <= pat_in;
    end
  end

  assign win_out = win;
  assign pat_out = pat;

  // The incoming byte is what this cell holds after the shift. Cells beyond the
  // pattern length do not take part in the compare.
  assign hit = (pattern_length <= LEN_WIDTH'(IDX)) || (win_in == pat);

endmodule

### hdl/fsmatch_obuf.sv
module fsmatch_obuf #(
  parameter int INDEX_WIDTH = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  logic                    push_found,
  input  logic [INDEX_WIDTH:0]    push_index,
  output logic                    full,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    found,
  output logic [INDEX_WIDTH:0]    match_index
);
  import fsmatch_pkg::*;

  logic                 skid_valid;
  logic                 skid_found;
  logic [INDEX_WIDTH:0] skid_index;
  logic                 pop;

  assign pop  = out_valid && out_ready;
  assign full = skid_valid;

  // Valid flags of the output register and the skid stage.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (pop) begin
        out_valid  <= skid_valid || push;
        skid_valid <= 1'b0;
      end else if (!out_valid) begin
        out_valid <= push;
      end else if (push) begin
        skid_valid <= 1'b1;
      end
    end
  end

  // Payload moves into the output register or parks in the skid stage.
  always_ff @(posedge clk) begin
    if (pop && skid_valid) begin
      found       <= skid_found;
      match_index <= skid_index;
    end else if (push && (pop || !out_valid)) begin
      found       <= push_found;
      match_index <= push_index;
    end
    if (push && out_valid && !pop) begin
      skid_found <= push_found;
      skid_index <= push_index;
    end
  end

  // The skid stage only fills behind a waiting result.
  a_skid_behind_out: assert property (@(posedge clk) disable iff (rst)
    skid_valid |-> out_valid)
    else $error("skid stage holds a result while the output register is empty");

  // No new result may arrive while both stages are occupied.
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !skid_valid)
    else $error("result pushed into a full output buffer");

  // A waiting result stays until it is taken.
  a_out_held: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(match_index) && $stable(found)))
    else $error("waiting result changed before it was taken");

endmodule
